[rtl/brle_pkg.sv]
// Shared types and constants for the bit-packed run-length decoder.
`timescale 1ns / 1ps
package brle_pkg;

   localparam int DEFAULT_COUNT_BITS  = 6;
   localparam int DEFAULT_QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS         = 64;
   localparam int DATA_W              = 8;
   localparam int RES_CNT_W           = 7;   // holds 0..MAX_RESULTS

   typedef enum logic [2:0] {
      PH_KIND  = 3'd0,
      PH_COUNT = 3'd1,
      PH_LIT   = 3'd2,
      PH_REP   = 3'd3
   } phase_type;

   // One decoded command: rep_count copies of data, then (if has_end)
   // the end marker, merged into the last copy when the list is full.
   typedef struct packed {
      logic [DATA_W-1:0]    data;
      logic [RES_CNT_W-1:0] rep_count;
      logic [RES_CNT_W-1:0] total;
      logic                 has_end;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

endpackage

[rtl/brle_front.sv]
// Front end: parses one compressed byte per word into a result command.
`timescale 1ns / 1ps
module brle_front #(
   parameter int COUNT_BITS = brle_pkg::DEFAULT_COUNT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tuser,
   input  logic              q_full,
   output logic              push,
   output brle_pkg::cmd_type push_cmd
);
   import brle_pkg::*;

   localparam int RCW = COUNT_BITS + 1;

   logic [DATA_W-1:0] bit_buffer_ff, bit_buffer_in;
   logic [3:0]        bits_held_ff, bits_held_in;
   phase_type         phase_ff, phase_in;
   logic              kind_ff, kind_in;
   logic [RCW-1:0]    run_count_ff, run_count_in;
   logic              done_ff, done_in;

   logic                 accept;
   logic [DATA_W-1:0]    data_c;
   logic [RES_CNT_W-1:0] rep_c;
   logic                 end_c;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Up to eight narrow dependent steps, one per bit, MSB first.
   always_comb begin
      logic [COUNT_BITS-1:0] cnt;
      bit_buffer_in = bit_buffer_ff;
      bits_held_in  = bits_held_ff;
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      run_count_in  = run_count_ff;
      done_in       = done_ff;
      data_c        = '0;
      rep_c         = '0;
      end_c         = 1'b0;
      cnt           = '0;
      if (req_tuser) begin
         bit_buffer_in = '0;
         bits_held_in  = '0;
         phase_in      = PH_KIND;
         kind_in       = 1'b0;
         run_count_in  = '0;
         done_in       = 1'b0;
      end
      for (int i = 7; i >= 0; i--) begin
         if (!done_in) begin
            case (phase_in)
               PH_COUNT: begin
                  bit_buffer_in = {bit_buffer_in[DATA_W-2:0], req_tdata[i]};
                  bits_held_in  = bits_held_in + 4'd1;
                  if (bits_held_in == 4'(COUNT_BITS)) begin
                     cnt           = bit_buffer_in[COUNT_BITS-1:0];
                     bit_buffer_in = '0;
                     bits_held_in  = '0;
                     if (!kind_in) begin
                        run_count_in = RCW'(cnt) + RCW'(1);
                        phase_in     = PH_LIT;
                     end else if (cnt == '0) begin
                        end_c    = 1'b1;
                        done_in  = 1'b1;
                        phase_in = PH_KIND;
                     end else begin
                        run_count_in = RCW'(cnt) + RCW'(1);
                        phase_in     = PH_REP;
                     end
                  end
               end
               PH_LIT, PH_REP: begin
                  bit_buffer_in = {bit_buffer_in[DATA_W-2:0], req_tdata[i]};
                  bits_held_in  = bits_held_in + 4'd1;
                  if (bits_held_in == 4'(DATA_W)) begin
                     data_c = bit_buffer_in;
                     if (phase_in == PH_LIT) begin
                        rep_c        = RES_CNT_W'(1);
                        run_count_in = run_count_in - RCW'(1);
                        if (run_count_in == '0) begin
                           phase_in = PH_KIND;
                        end
                     end else begin
                        if (int'(run_count_in) > MAX_RESULTS) begin
                           rep_c = RES_CNT_W'(MAX_RESULTS);
                        end else begin
                           rep_c = RES_CNT_W'(run_count_in);
                        end
                        run_count_in = '0;
                        phase_in     = PH_KIND;
                     end
                     bit_buffer_in = '0;
                     bits_held_in  = '0;
                  end
               end
               default: begin
                  // expect kind bit; unknown codes land here too
                  kind_in       = req_tdata[i];
                  bit_buffer_in = '0;
                  bits_held_in  = '0;
                  phase_in      = PH_COUNT;
               end
            endcase
         end
      end
   end

   always_comb begin
      push_cmd.data      = data_c;
      push_cmd.rep_count = rep_c;
      push_cmd.has_end   = end_c;
      // a full list takes the end marker on its last copy
      if (end_c && rep_c != RES_CNT_W'(MAX_RESULTS)) begin
         push_cmd.total = rep_c + RES_CNT_W'(1);
      end else begin
         push_cmd.total = rep_c;
      end
   end

   assign push = accept && (push_cmd.total != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_buffer_ff <= '0;
         bits_held_ff  <= '0;
         phase_ff      <= PH_KIND;
         kind_ff       <= 1'b0;
         run_count_ff  <= '0;
         done_ff       <= 1'b0;
      end else if (accept) begin
         bit_buffer_ff <= bit_buffer_in;
         bits_held_ff  <= bits_held_in;
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         run_count_ff  <= run_count_in;
         done_ff       <= done_in;
      end
   end

endmodule

[rtl/brle_queue.sv]
// Command queue between the parser and the result emitter.
`timescale 1ns / 1ps
module brle_queue #(
   parameter int DEPTH = brle_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  brle_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output logic                 full,
   output brle_pkg::q_head_type head
);
   import brle_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/brle_back.sv]
// Back end: expands queued commands into result words, one per cycle while the consumer accepts.
`timescale 1ns / 1ps
module brle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  brle_pkg::q_head_type head,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import brle_pkg::*;

   logic [RES_CNT_W-1:0] idx_ff, idx_in;
   logic                 valid_ff;
   logic [DATA_W-1:0]    byte_ff, byte_in;
   logic                 bvalid_ff, bvalid_in;
   logic                 end_ff, end_in;
   logic                 last_ff, last_in;
   logic                 load;

   assign load = head.valid && (!valid_ff || rsp_tready);
   assign pop  = load && last_in;

   always_comb begin
      last_in   = (idx_ff == head.cmd.total - RES_CNT_W'(1));
      bvalid_in = (idx_ff < head.cmd.rep_count);
      byte_in   = bvalid_in ? head.cmd.data : '0;
      end_in    = head.cmd.has_end && last_in;
      idx_in    = last_in ? '0 : idx_ff + RES_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         end_ff    <= end_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {end_ff, bvalid_ff};
   assign rsp_tlast  = last_ff;

endmodule

[rtl/bitpacked_rle_decoder.sv]
// Top level of the bit-packed literal/repeat run-length decoder.
// Path: a result word is registered in the command queue and then in the output stage before it is offered.
// Throughput: the parser takes one word per cycle while the command queue has room;
//   the emitter gives one result word per cycle while the consumer accepts.
// Reset: synchronous, active high; clears parser state, queue and output valid.
`timescale 1ns / 1ps
module bitpacked_rle_decoder #(
   parameter int COUNT_BITS  = brle_pkg::DEFAULT_COUNT_BITS,   // 1..8
   parameter int QUEUE_DEPTH = brle_pkg::DEFAULT_QUEUE_DEPTH   // 2..16
) (
   input  logic       clock,
   input  logic       reset,
   // compressed input
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tuser,    // [0] new_stream
   // decoded results
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic [1:0] rsp_tuser,    // [0] byte_valid, [1] stream_end
   output logic       rsp_tlast     // last result caused by one input word
);
   import brle_pkg::*;

   logic       q_full;
   logic       push;
   logic       pop;
   cmd_type    push_cmd;
   q_head_type head;

   // Parser: the bit buffer and token state advance a whole word at a time.
   // A word that decodes nothing (or arrives after the end marker) is
   // taken and dropped without touching the queue.
   brle_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Short queue so the parser keeps running while a long repeat run drains.
   brle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .head     (head)
   );

   // Emitter: walks each command, one result word per cycle while the consumer
   // accepts, into a registered output stage.
   brle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
